// ===== src/tdpt_pkg.sv =====
`timescale 1ns / 1ps

package tdpt_pkg;

   // Width of the port that carries a candidate.
   localparam int CANDIDATE_W = 64;

   // Bits of the candidate that take part in the test (2 .. CANDIDATE_W).
   localparam int NUMBER_WIDTH = 64;

   // Divisor and remainder width: wide enough to hold the first trial divisors
   // even for the narrowest number width.
   localparam int WORK_W = NUMBER_WIDTH + 4;

   // Bit counter of the shared divider, able to hold NUMBER_WIDTH itself.
   localparam int COUNT_W = $clog2(NUMBER_WIDTH + 1);

   // Trial divisors.
   localparam logic [WORK_W-1:0] DIV_THREE  = WORK_W'(3);
   localparam logic [WORK_W-1:0] DIV_FIRST  = WORK_W'(5);
   localparam logic [WORK_W-1:0] STEP_PAIR  = WORK_W'(2);
   localparam logic [WORK_W-1:0] STEP_NEXT  = WORK_W'(4);

   typedef logic [NUMBER_WIDTH-1:0] number_type;
   typedef logic [WORK_W-1:0]       work_type;

endpackage

// ===== src/trial_division_primality_test.sv =====
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Handshake
// --------  -----------------------------  ---------  -------------------------------
// request   start, busy, req_candidate     in         taken when start & !busy
// result    rsp_valid, rsp_is_prime        out        one-cycle strobe, never stalled
//
// One restoring divider, one quotient bit per cycle, is shared by every trial
// division; a division shifts through every bit of the number, then an
// evaluation step follows. Candidates below 4 or even are decided in the check
// state without a division; others cost one division per trial divisor, i.e.
// up to about 2 * sqrt(n) / 6 divisions for a prime n.
// Reset is synchronous and active high; it returns the sequencer to idle.
// busy is high from acceptance until the cycle the result is strobed; the
// receiver cannot stall, so rsp_valid lasts exactly one cycle.
module trial_division_primality_test (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tdpt_pkg::CANDIDATE_W-1:0] req_candidate,
   output logic                           rsp_valid,
   output logic                           rsp_is_prime
);
   import tdpt_pkg::*;

   // Sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_EVAL  = 2'd3;

   // What the running division is for
   localparam logic [1:0] PH_THREE = 2'd0;  // divisor 3
   localparam logic [1:0] PH_LOW   = 2'd1;  // divisor i = 6k-1, also loop bound
   localparam logic [1:0] PH_HIGH  = 2'd2;  // divisor i+2 = 6k+1

   logic [1:0]         state_ff, state_in;
   logic [1:0]         phase_ff, phase_in;
   number_type         n_ff, n_in;
   number_type         q_ff, q_in;
   work_type           rem_ff, rem_in;
   work_type           div_ff, div_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               valid_ff, valid_in;
   logic               prime_ff, prime_in;

   // Divider step
   logic [WORK_W:0]    trial;
   logic [WORK_W:0]    diff;
   logic               ge;

   assign trial = {rem_ff, q_ff[NUMBER_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      n_in     = n_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      valid_in = 1'b0;
      prime_in = prime_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // take only the bits in play
               n_in     = req_candidate[NUMBER_WIDTH-1:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (n_ff < NUMBER_WIDTH'(2)) begin
               valid_in = 1'b1;
               prime_in = 1'b0;
               state_in = ST_IDLE;
            end else if (n_ff == NUMBER_WIDTH'(2) || n_ff == NUMBER_WIDTH'(3)) begin
               valid_in = 1'b1;
               prime_in = 1'b1;
               state_in = ST_IDLE;
            end else if (!n_ff[0]) begin
               valid_in = 1'b1;
               prime_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               // launch the division by three
               div_in   = DIV_THREE;
               phase_in = PH_THREE;
               rem_in   = '0;
               q_in     = n_ff;
               count_in = COUNT_W'(NUMBER_WIDTH);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // shift in one dividend bit, subtract where it fits
            rem_in   = ge ? diff[WORK_W-1:0] : trial[WORK_W-1:0];
            q_in     = {q_ff[NUMBER_WIDTH-2:0], ge};
            count_in = count_ff - COUNT_W'(1);
            if (count_ff == COUNT_W'(1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // defaults for the next division
            rem_in   = '0;
            q_in     = n_ff;
            count_in = COUNT_W'(NUMBER_WIDTH);
            state_in = ST_DIV;
            case (phase_ff)
               PH_THREE: begin
                  div_in   = DIV_FIRST;
                  phase_in = PH_LOW;
               end
               PH_LOW: begin
                  div_in   = div_ff + STEP_PAIR;
                  phase_in = PH_HIGH;
               end
               default: begin
                  div_in   = div_ff + STEP_NEXT;
                  phase_in = PH_LOW;
               end
            endcase
            // i > n / i: no divisor left to try, so the candidate is prime
            if (phase_ff == PH_LOW &&
                div_ff > {{(WORK_W-NUMBER_WIDTH){1'b0}}, q_ff}) begin
               valid_in = 1'b1;
               prime_in = 1'b1;
               state_in = ST_IDLE;
            end else if (rem_ff == '0) begin
               // exact divisor found
               valid_in = 1'b1;
               prime_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Payload and datapath: hold unless the sequencer moves them
   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      n_ff     <= n_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      count_ff <= count_in;
      prime_ff <= prime_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = valid_ff;
   assign rsp_is_prime = prime_ff;

endmodule

// ===== test/tdpt_flag_checker.sv =====
`timescale 1ns / 1ps

module tdpt_flag_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [tdpt_pkg::CANDIDATE_W-1:0] req_candidate,
   input  logic                             rsp_valid,
   input  logic                             rsp_is_prime,
   output int                               mismatches,
   output int                               outstanding
);

   typedef struct {
      logic [tdpt_pkg::CANDIDATE_W-1:0] candidate;
      logic                             is_prime;
   } verdict_type;

   verdict_type expected_verdicts [$];

   // Trial division over 6k-1 and 6k+1; the bound i*i <= n is kept as i <= n/i.
   function automatic logic prime_flag(logic [tdpt_pkg::CANDIDATE_W-1:0] candidate);
      tdpt_pkg::number_type number;
      logic [63:0]          n;
      logic [63:0]          i;
      number = candidate[tdpt_pkg::NUMBER_WIDTH-1:0];
      n = 64'(number);
      if (n < 64'd2) return 1'b0;
      if (n == 64'd2 || n == 64'd3) return 1'b1;
      if (n % 64'd2 == 64'd0 || n % 64'd3 == 64'd0) return 1'b0;
      for (i = 64'd5; i <= n / i; i += 64'd6) begin
         if (n % i == 64'd0 || n % (i + 64'd2) == 64'd0) return 1'b0;
      end
      return 1'b1;
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      verdict_type entry;
      verdict_type head;
      if (reset) begin
         expected_verdicts.delete();
      end else begin
         if (start && !busy) begin
            entry.candidate = req_candidate;
            entry.is_prime  = prime_flag(req_candidate);
            expected_verdicts.push_back(entry);
         end
         if (rsp_valid) begin
            if (expected_verdicts.size() == 0) begin
               $error("rsp_is_prime: result with no request waiting, expected none, actual %0b",
                      rsp_is_prime);
               mismatches <= mismatches + 1;
            end else begin
               head = expected_verdicts.pop_front();
               if (rsp_is_prime !== head.is_prime) begin
                  $error("rsp_is_prime: expected %0b, actual %0b (candidate %0d)",
                         head.is_prime, rsp_is_prime, head.candidate);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
      outstanding <= expected_verdicts.size();
   end

endmodule

// ===== test/trial_division_primality_test_test.sv =====
`timescale 1ns / 1ps

module trial_division_primality_test_test;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [tdpt_pkg::CANDIDATE_W-1:0] req_candidate;
   logic                             rsp_valid;
   logic                             rsp_is_prime;
   int                               mismatches;
   int                               outstanding;

   // Corner candidates: the ends of the range, every early exit (below two, two and
   // three, multiples of two and three), squares of primes that hit the loop bound
   // exactly on either member of a pair, and the largest primes below 2^12, 2^16
   // and 2^18. Top-of-range values all carry a small factor: a large prime would
   // keep the divider busy until the watchdog stops the run.
   logic [63:0] corner_cases [24] = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd9,
      64'd25, 64'd35, 64'd49, 64'd121, 64'd169, 64'd289, 64'd323,
      64'd4093, 64'd65521, 64'd262139,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
      64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'h5555_5555_5555_5555
   };

   trial_division_primality_test u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_is_prime  (rsp_is_prime)
   );

   tdpt_flag_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_is_prime  (rsp_is_prime),
      .mismatches    (mismatches),
      .outstanding   (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Random candidate. Keep most of them small, since a prime costs about
   // sqrt(n)/3 divisions. Full-width values get a forced small factor so that
   // the divider drops out of the loop early.
   function automatic logic [63:0] pick_candidate();
      int unsigned sel;
      int unsigned factor;
      logic [63:0] wide;
      logic [63:0] left_factor;
      logic [63:0] right_factor;
      sel = $urandom_range(99);
      if (sel < 50) return 64'($urandom_range(4095));
      if (sel < 70) return 64'($urandom_range(65535));
      if (sel < 75) return 64'($urandom_range(262143));
      if (sel < 82) begin
         // products of two numbers of the form 6k+-1: the slowest composites
         left_factor  = 64'(6 * $urandom_range(1, 85)) + ($urandom_range(1) ? 64'd1 : -64'd1);
         right_factor = 64'(6 * $urandom_range(1, 85)) + ($urandom_range(1) ? 64'd1 : -64'd1);
         return left_factor * right_factor;
      end
      case ($urandom_range(5))
         0: factor = 2;
         1: factor = 3;
         2: factor = 5;
         3: factor = 7;
         4: factor = 31;
         default: factor = 47;
      endcase
      wide = {$urandom, $urandom};
      return wide - wide % 64'(factor);
   endfunction

   // Present one request from a falling edge and hold it until the block takes
   // it. start stays high on return so that a back-to-back request needs no
   // second assignment in the same step.
   task automatic send_request(logic [63:0] candidate);
      start         <= 1'b1;
      req_candidate <= candidate;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Drop start for a while and scramble the idle payload. Most gaps are short;
   // a few run long enough to land anywhere inside a division sequence.
   task automatic idle_gap();
      int unsigned gap;
      gap = ($urandom_range(99) < 80) ? $urandom_range(1, 4) : $urandom_range(5, 300);
      start         <= 1'b0;
      req_candidate <= {$urandom, $urandom};
      repeat (gap) @(negedge clock);
   endtask

   // Drop start and hold off until every outstanding verdict has come back.
   task automatic drain();
      start <= 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_candidate = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, back to back apart from the odd gap
      foreach (corner_cases[k]) begin
         if ($urandom_range(99) < 16) idle_gap();
         send_request(corner_cases[k]);
      end
      drain();

      // random part; a quiet window with no gaps sits in the middle, and the
      // sender drains the block completely every so often
      for (int k = 0; k < 600; k++) begin
         if ((k < 250 || k >= 380) && $urandom_range(99) < 16) idle_gap();
         send_request(pick_candidate());
         if (k % 150 == 149) drain();
      end

      start <= 1'b0;
      wait (outstanding == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: several times the slowest run that the stimulus above allows.
   initial begin
      #250_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== trial_division_primality_test.f =====
src/tdpt_pkg.sv
src/trial_division_primality_test.sv
test/tdpt_flag_checker.sv
test/trial_division_primality_test_test.sv
